@@ hw/rtl/mfbre_pkg.sv @@
// ----------------------------------------------------------------------------
// Frame store raster engine package
// Shared constants, command codes and the control/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package mfbre_pkg;

  // Default screen geometry.
  localparam int DEF_COLUMNS = 128;
  localparam int DEF_ROWS    = 64;

  // Field and internal widths.
  localparam int OP_W    = 3;
  localparam int FIELD_W = 10;
  localparam int CW      = 12;   // walk coordinates, with room for clip bounds
  localparam int XOFF_W  = 7;
  localparam int ERR_W   = 13;   // Bresenham error term
  localparam int SQ_W    = 18;   // squares of a 9-bit magnitude and multiplier inputs
  localparam int PROD_W  = 2 * SQ_W;

  localparam logic [XOFF_W-1:0] XOFF_RESET = 7'd6;

  // Command codes.
  typedef enum logic [OP_W-1:0] {
    OP_PIXEL = 3'd0,
    OP_LINE  = 3'd1,
    OP_RECT  = 3'd2,
    OP_OVAL  = 3'd3,
    OP_CLEAR = 3'd4,
    OP_READ  = 3'd5
  } op_t;

  // Operand selection and destination of the shared multiplier.
  typedef enum logic [2:0] {
    MUL_NONE = 3'd0,
    MUL_RX2  = 3'd1,
    MUL_RY2  = 3'd2,
    MUL_LIM  = 3'd3,
    MUL_DY2  = 3'd4,
    MUL_DYT  = 3'd5,
    MUL_DX2  = 3'd6,
    MUL_DXT  = 3'd7
  } mul_sel_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic     in_fire;
    logic     setup;
    logic     walk_init;
    logic     res_clear;
    logic     res_read;
    logic     mem_rd;
    logic     mem_wr;
    logic     rd_read_addr;
    logic     clr_start;
    logic     clr_step;
    logic     clr_sel;
    logic     step_x;
    logic     row_next;
    logic     line_step;
    mul_sel_t mul_sel;
    logic     out_load;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            shape_empty;
    logic            on_screen;
    logic            x_last;
    logic            y_last;
    logic            line_end;
    logic            in_shape;
    logic            clr_last;
    logic            read_ok;
    logic            out_free;
  } dp_sts_t;

endpackage

@@ hw/rtl/mfbre_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, either a write or a registered read.
// ----------------------------------------------------------------------------
module mfbre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic                     re,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ hw/rtl/mfbre_ctrl.sv @@
// ----------------------------------------------------------------------------
// Frame store raster engine controller
// Sequences each command: clear sweeps, read-modify-write pixel plots, the
// line walk, rectangle and ellipse scans and the ellipse inside test.
// ----------------------------------------------------------------------------
module mfbre_ctrl import mfbre_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [16:0] {
    S_INIT      = 17'b00000000000000001,
    S_IDLE      = 17'b00000000000000010,
    S_DISPATCH  = 17'b00000000000000100,
    S_CHECK     = 17'b00000000000001000,
    S_CLEAR     = 17'b00000000000010000,
    S_READ_WAIT = 17'b00000000000100000,
    S_PLOT_RD   = 17'b00000000001000000,
    S_PLOT_WR   = 17'b00000000010000000,
    S_E_RX2     = 17'b00000000100000000,
    S_E_RY2     = 17'b00000001000000000,
    S_E_LIM     = 17'b00000010000000000,
    S_E_DY2     = 17'b00000100000000000,
    S_E_DYT     = 17'b00001000000000000,
    S_E_DX2     = 17'b00010000000000000,
    S_E_DXT     = 17'b00100000000000000,
    S_E_TEST    = 17'b01000000000000000,
    S_FINISH    = 17'b10000000000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   is_oval;

  assign in_ready = (state == S_IDLE);
  assign is_oval  = (sts.op == OP_OVAL);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    cmd        = '0;
    state_next = state;
    cmd.in_fire = in_valid && in_ready;
    case (state)
      S_INIT: begin
        cmd.clr_sel  = 1'b1;
        cmd.mem_wr   = 1'b1;
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.setup     = 1'b1;
        cmd.res_clear = 1'b1;
        case (sts.op)
          OP_PIXEL, OP_LINE: state_next = S_PLOT_RD;
          OP_RECT, OP_OVAL:  state_next = S_CHECK;
          OP_CLEAR: begin
            cmd.clr_start = 1'b1;
            state_next    = S_CLEAR;
          end
          OP_READ: begin
            if (sts.read_ok) begin
              cmd.mem_rd       = 1'b1;
              cmd.rd_read_addr = 1'b1;
              state_next       = S_READ_WAIT;
            end else begin
              state_next = S_FINISH;
            end
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_CHECK: begin
        if (sts.shape_empty) begin
          state_next = S_FINISH;
        end else begin
          cmd.walk_init = 1'b1;
          state_next    = is_oval ? S_E_RX2 : S_PLOT_RD;
        end
      end
      S_CLEAR: begin
        cmd.clr_sel  = 1'b1;
        cmd.mem_wr   = 1'b1;
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_FINISH;
        end
      end
      S_READ_WAIT: begin
        cmd.res_read = 1'b1;
        state_next   = S_FINISH;
      end
      S_E_RX2: begin
        cmd.mul_sel = MUL_RX2;
        state_next  = S_E_RY2;
      end
      S_E_RY2: begin
        cmd.mul_sel = MUL_RY2;
        state_next  = S_E_LIM;
      end
      S_E_LIM: begin
        cmd.mul_sel = MUL_LIM;
        state_next  = S_E_DY2;
      end
      S_E_DY2: begin
        cmd.mul_sel = MUL_DY2;
        state_next  = S_E_DYT;
      end
      S_E_DYT: begin
        cmd.mul_sel = MUL_DYT;
        state_next  = S_E_DX2;
      end
      S_E_DX2: begin
        cmd.mul_sel = MUL_DX2;
        state_next  = S_E_DXT;
      end
      S_E_DXT: begin
        cmd.mul_sel = MUL_DXT;
        state_next  = S_E_TEST;
      end
      S_PLOT_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_PLOT_WR;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    // Plot the pixel, or skip the write when it lies off screen.
    if (state == S_PLOT_WR) begin
      cmd.mem_wr = sts.on_screen;
    end
    if ((state == S_PLOT_WR && sts.op == OP_PIXEL)) begin
      state_next = S_FINISH;
    end else if (state == S_PLOT_WR && sts.op == OP_LINE) begin
      if (sts.line_end) begin
        state_next = S_FINISH;
      end else begin
        cmd.line_step = 1'b1;
        state_next    = S_PLOT_RD;
      end
    end else if ((state == S_PLOT_WR) || (state == S_E_TEST && !sts.in_shape)) begin
      // Scan advance for rectangles and ellipses.
      if (sts.x_last && sts.y_last) begin
        state_next = S_FINISH;
      end else if (sts.x_last) begin
        cmd.row_next = 1'b1;
        state_next   = is_oval ? S_E_DY2 : S_PLOT_RD;
      end else begin
        cmd.step_x = 1'b1;
        state_next = is_oval ? S_E_DX2 : S_PLOT_RD;
      end
    end else if (state == S_E_TEST) begin
      state_next = S_PLOT_RD;
    end
  end

  // An accepted command is always dispatched in the next cycle.
  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DISPATCH))
    else $error("accepted command not dispatched");

  // A plot write completes a read issued in the previous cycle.
  a_rmw_order: assert property (@(posedge clk) disable iff (rst)
    (cmd.mem_wr && !cmd.clr_sel) |-> $past(cmd.mem_rd))
    else $error("pixel write without preceding read");

  // The result register is only loaded when it is free.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result overwritten before taken");

  // The write half of a plot always follows its read half.
  a_plot_seq: assert property (@(posedge clk) disable iff (rst)
    (state == S_PLOT_WR) |-> ($past(state) == S_PLOT_RD))
    else $error("plot write state entered out of order");

endmodule

@@ hw/rtl/mfbre_dpath.sv @@
// ----------------------------------------------------------------------------
// Frame store raster engine datapath
// Holds the command, offset, walk and clip registers, the Bresenham error
// term, the shared ellipse multiplier, the frame store and the result beat.
// ----------------------------------------------------------------------------
module mfbre_dpath import mfbre_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEF_COLUMNS,
  parameter int SCREEN_ROWS    = DEF_ROWS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  dp_cmd_t                   cmd,
  output dp_sts_t                   sts,
  input  logic                      cfg_we,
  input  logic [XOFF_W-1:0]         cfg_data,
  input  logic [OP_W-1:0]           op,
  input  logic signed [FIELD_W-1:0] start_x,
  input  logic signed [FIELD_W-1:0] start_y,
  input  logic signed [FIELD_W-1:0] param_a,
  input  logic signed [FIELD_W-1:0] param_b,
  input  logic                      color,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                read_data,
  output logic                      status
);

  localparam int PAGES  = (SCREEN_ROWS + 7) / 8;
  localparam int DEPTH  = SCREEN_COLUMNS * PAGES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int COL_W  = $clog2(SCREEN_COLUMNS);
  localparam logic signed [CW-1:0] COL_MAX  = CW'(SCREEN_COLUMNS - 1);
  localparam logic signed [CW-1:0] ROW_MAX  = CW'(SCREEN_ROWS - 1);
  localparam logic signed [CW-1:0] PAGE_MAX = CW'(PAGES - 1);
  localparam logic signed [CW-1:0] ONE      = CW'(1);
  localparam logic [ADDR_W-1:0]    LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0]    COLS_A    = ADDR_W'(SCREEN_COLUMNS);

  // Command and configuration registers.
  logic [XOFF_W-1:0]         col_offset;
  logic [OP_W-1:0]           op_q;
  logic signed [FIELD_W-1:0] sx_q, sy_q, pa_q, pb_q;
  logic                      color_q;

  // Walk, clip and line registers.
  logic signed [CW-1:0]    wx, wy;
  logic signed [CW-1:0]    x_lo, x_hi, y_lo, y_hi;
  logic                    shape_bad;
  logic signed [ERR_W-1:0] ldx, ldy, err;
  logic                    step_right, step_down;

  // Ellipse terms.
  logic [SQ_W-1:0]   rx2, ry2, dysq, dxsq;
  logic [PROD_W-1:0] lim, dyterm, dxterm;

  // Clear counter and result registers.
  logic [ADDR_W-1:0] clr_addr;
  logic [7:0]        res_data;
  logic              res_status;

  // Combinational terms.
  logic signed [CW-1:0]    sx_e, sy_e, pa_e, pb_e, off_e;
  logic                    is_oval;
  logic signed [CW-1:0]    bnd_a, bnd_b, bnd_c, bnd_d, lim_xl, lim_xh;
  logic signed [CW-1:0]    ddx, ddy, adx_l, ady_l;
  logic signed [ERR_W-1:0] ldx_n, ldy_n;
  logic signed [ERR_W:0]   e2, ldx_w, ldy_w;
  logic                    mov_x, mov_y;
  logic signed [CW-1:0]    dxv, dyv, adxv, adyv;
  logic [SQ_W-1:0]         mul_a, mul_b;
  logic [PROD_W-1:0]       prod;
  logic [PROD_W:0]         ell_sum;
  logic signed [CW-1:0]    px;
  logic [ADDR_W-1:0]       plot_addr, read_addr, ram_addr;
  logic [7:0]              ram_rdata, ram_wdata, bit_mask, modified;
  logic                    read_ok;

  assign sx_e    = {{(CW-FIELD_W){sx_q[FIELD_W-1]}}, sx_q};
  assign sy_e    = {{(CW-FIELD_W){sy_q[FIELD_W-1]}}, sy_q};
  assign pa_e    = {{(CW-FIELD_W){pa_q[FIELD_W-1]}}, pa_q};
  assign pb_e    = {{(CW-FIELD_W){pb_q[FIELD_W-1]}}, pb_q};
  assign off_e   = {{(CW-XOFF_W){1'b0}}, col_offset};
  assign is_oval = (op_q == OP_OVAL);

  // Shape extents and their clip limits.
  assign bnd_a  = is_oval ? (sx_e - pa_e) : sx_e;
  assign bnd_b  = is_oval ? (sx_e + pa_e) : (sx_e + pa_e - ONE);
  assign bnd_c  = is_oval ? (sy_e - pb_e) : sy_e;
  assign bnd_d  = is_oval ? (sy_e + pb_e) : (sy_e + pb_e - ONE);
  assign lim_xl = -off_e;
  assign lim_xh = COL_MAX - off_e;

  // Line setup terms.
  assign ddx   = pa_e - sx_e;
  assign ddy   = pb_e - sy_e;
  assign adx_l = (ddx < 0) ? -ddx : ddx;
  assign ady_l = (ddy < 0) ? -ddy : ddy;
  assign ldx_n = {{(ERR_W-CW){1'b0}}, adx_l};
  assign ldy_n = -{{(ERR_W-CW){1'b0}}, ady_l};

  // Bresenham step decision.
  assign e2    = {err, 1'b0};
  assign ldx_w = {ldx[ERR_W-1], ldx};
  assign ldy_w = {ldy[ERR_W-1], ldy};
  assign mov_x = (e2 >= ldy_w);
  assign mov_y = (e2 <= ldx_w);

  // Offsets from the ellipse center; both stay within the radii.
  assign dxv  = wx - sx_e;
  assign dyv  = wy - sy_e;
  assign adxv = (dxv < 0) ? -dxv : dxv;
  assign adyv = (dyv < 0) ? -dyv : dyv;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MUL_RX2: begin
        mul_a = {{(SQ_W-FIELD_W){1'b0}}, pa_q};
        mul_b = {{(SQ_W-FIELD_W){1'b0}}, pa_q};
      end
      MUL_RY2: begin
        mul_a = {{(SQ_W-FIELD_W){1'b0}}, pb_q};
        mul_b = {{(SQ_W-FIELD_W){1'b0}}, pb_q};
      end
      MUL_LIM: begin
        mul_a = rx2;
        mul_b = ry2;
      end
      MUL_DY2: begin
        mul_a = {{(SQ_W-FIELD_W){1'b0}}, adyv[FIELD_W-1:0]};
        mul_b = {{(SQ_W-FIELD_W){1'b0}}, adyv[FIELD_W-1:0]};
      end
      MUL_DYT: begin
        mul_a = dysq;
        mul_b = rx2;
      end
      MUL_DX2: begin
        mul_a = {{(SQ_W-FIELD_W){1'b0}}, adxv[FIELD_W-1:0]};
        mul_b = {{(SQ_W-FIELD_W){1'b0}}, adxv[FIELD_W-1:0]};
      end
      MUL_DXT: begin
        mul_a = dxsq;
        mul_b = ry2;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign ell_sum = {1'b0, dxterm} + {1'b0, dyterm};

  // Pixel address, clip test and read address.
  assign px        = wx + off_e;
  assign plot_addr = ADDR_W'(px[COL_W-1:0]) + ADDR_W'(wy[PAGE_W+2:3]) * COLS_A;
  assign read_addr = ADDR_W'(sx_q[COL_W-1:0]) + ADDR_W'(sy_q[PAGE_W-1:0]) * COLS_A;
  assign read_ok   = (sx_e >= 0) && (sx_e <= COL_MAX) && (sy_e >= 0) && (sy_e <= PAGE_MAX);
  assign bit_mask  = 8'b1 << wy[2:0];
  assign modified  = color_q ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);

  // Frame store port selection.
  always_comb begin
    if (cmd.clr_sel) begin
      ram_addr = clr_addr;
    end else if (cmd.rd_read_addr) begin
      ram_addr = read_addr;
    end else begin
      ram_addr = plot_addr;
    end
  end
  assign ram_wdata = cmd.clr_sel ? 8'h00 : modified;

  mfbre_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (cmd.mem_wr),
    .re    (cmd.mem_rd),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Offset register.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_offset <= XOFF_RESET;
    end else if (cfg_we) begin
      col_offset <= cfg_data;
    end
  end

  // Command capture.
  always_ff @(posedge clk) begin
    if (cmd.in_fire) begin
      op_q    <= op;
      sx_q    <= start_x;
      sy_q    <= start_y;
      pa_q    <= param_a;
      pb_q    <= param_b;
      color_q <= color;
    end
  end

  // Clip bounds and line setup.
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      x_lo       <= (bnd_a > lim_xl) ? bnd_a : lim_xl;
      x_hi       <= (bnd_b < lim_xh) ? bnd_b : lim_xh;
      y_lo       <= (bnd_c > 0) ? bnd_c : '0;
      y_hi       <= (bnd_d < ROW_MAX) ? bnd_d : ROW_MAX;
      shape_bad  <= is_oval ? (pa_q < 0 || pb_q < 0) : (pa_q <= 0 || pb_q <= 0);
      ldx        <= ldx_n;
      ldy        <= ldy_n;
      err        <= ldx_n + ldy_n;
      step_right <= (sx_e < pa_e);
      step_down  <= (sy_e < pb_e);
    end else if (cmd.line_step) begin
      err <= err + (mov_x ? ldy : '0) + (mov_y ? ldx : '0);
    end
  end

  // Walk position.
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      wx <= sx_e;
      wy <= sy_e;
    end else if (cmd.walk_init) begin
      wx <= x_lo;
      wy <= y_lo;
    end else if (cmd.step_x) begin
      wx <= wx + ONE;
    end else if (cmd.row_next) begin
      wx <= x_lo;
      wy <= wy + ONE;
    end else if (cmd.line_step) begin
      if (mov_x) begin
        wx <= step_right ? (wx + ONE) : (wx - ONE);
      end
      if (mov_y) begin
        wy <= step_down ? (wy + ONE) : (wy - ONE);
      end
    end
  end

  // Multiplier result registers.
  always_ff @(posedge clk) begin
    case (cmd.mul_sel)
      MUL_RX2: rx2    <= prod[SQ_W-1:0];
      MUL_RY2: ry2    <= prod[SQ_W-1:0];
      MUL_LIM: lim    <= prod;
      MUL_DY2: dysq   <= prod[SQ_W-1:0];
      MUL_DYT: dyterm <= prod;
      MUL_DX2: dxsq   <= prod[SQ_W-1:0];
      MUL_DXT: dxterm <= prod;
      default: ;
    endcase
  end

  // Clear sweep counter.
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  // Result of the current command.
  always_ff @(posedge clk) begin
    if (cmd.res_clear) begin
      res_data   <= 8'h00;
      res_status <= (op_q == OP_READ) && !read_ok;
    end else if (cmd.res_read) begin
      res_data <= ram_rdata;
    end
  end

  // Output beat register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_data <= res_data;
      status    <= res_status;
    end
  end

  // Status toward the controller.
  assign sts.op          = op_q;
  assign sts.shape_empty = shape_bad || (x_lo > x_hi) || (y_lo > y_hi);
  assign sts.on_screen   = (px >= 0) && (px <= COL_MAX) && (wy >= 0) && (wy <= ROW_MAX);
  assign sts.x_last      = (wx == x_hi);
  assign sts.y_last      = (wy == y_hi);
  assign sts.line_end    = (wx == pa_e) && (wy == pb_e);
  assign sts.in_shape    = (ell_sum <= {1'b0, lim});
  assign sts.clr_last    = (clr_addr == LAST_ADDR);
  assign sts.read_ok     = read_ok;
  assign sts.out_free    = !out_valid || out_ready;

endmodule

@@ hw/rtl/mono_framebuffer_raster_engine.sv @@
// ----------------------------------------------------------------------------
// Monochrome frame store raster engine
// Page-organized 1-bit frame store with pixel, line, rectangle, ellipse,
// clear and byte read commands.
// ----------------------------------------------------------------------------
// Each command beat yields exactly one result beat. Commands run one at a
// time; a new one is taken while the previous result still waits on the
// output. Every pixel is a read-modify-write of the single-port frame store,
// a read state then a write state. An ellipse first forms the squared radii
// and their product on the shared multiplier, then the squared row offset
// term for each scanned row, and the squared column offset term and the
// inside test for each scanned pixel of its clipped bounding box; only
// pixels inside are plotted. A clear sweeps all COLUMNS*PAGES (1024 by
// default) bytes and a read fetches one byte. After reset the store is swept
// to zero before the first command is accepted; offset writes are taken throughout.
// ----------------------------------------------------------------------------
module mono_framebuffer_raster_engine import mfbre_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEF_COLUMNS,
  parameter int SCREEN_ROWS    = DEF_ROWS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [XOFF_W-1:0]         cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [OP_W-1:0]           op,
  input  logic signed [FIELD_W-1:0] start_x,
  input  logic signed [FIELD_W-1:0] start_y,
  input  logic signed [FIELD_W-1:0] param_a,
  input  logic signed [FIELD_W-1:0] param_b,
  input  logic                      color,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                read_data,
  output logic                      status
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Command sequencer.
  mfbre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Registers, arithmetic and frame store.
  mfbre_dpath #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .op        (op),
    .start_x   (start_x),
    .start_y   (start_y),
    .param_a   (param_a),
    .param_b   (param_b),
    .color     (color),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data),
    .status    (status)
  );

endmodule
